[design/kfc_pkg.sv]
`timescale 1ns / 1ps
package kfc_pkg;

    localparam int WORD_BITS_DEF = 16;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_EQ    = 2'd2;
    localparam logic [1:0] KIND_CLR   = 2'd3;

    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_ADD  = 3'd1;
    localparam logic [2:0] PEND_SUB  = 3'd2;
    localparam logic [2:0] PEND_MUL  = 3'd3;
    localparam logic [2:0] PEND_DIV  = 3'd4;

    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_HOME   = 8'h80;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] RADIX      = 4'd10;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    typedef enum logic [2:0] {
        OSEL_KEY,
        OSEL_CLEAR,
        OSEL_HOME,
        OSEL_MINUS,
        OSEL_BUF
    } t_out_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT_KEY,
        ST_EMIT_LATCH,
        ST_EMIT_CLR,
        ST_EMIT_HOME,
        ST_EQ_CLR,
        ST_CALC,
        ST_DIV_WAIT,
        ST_DIV_FIN,
        ST_SIGN,
        ST_CONV,
        ST_CONV_FIN,
        ST_EMIT_DIG
    } t_state;

    typedef struct packed {
        logic     key_load;
        logic     entry_add;
        logic     op_latch;
        logic     op_set;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     calc_simple;
        logic     div_start;
        logic     div_conv;
        logic     div_finish;
        logic     mag_load;
        logic     dig_push;
        logic     dig_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       digit_big;
        logic       latched;
        logic       op_is_div;
        logic       div_busy;
        logic       out_free;
        logic       result_neg;
        logic       quo_zero;
        logic       dig_cnt_one;
    } t_dp_status;

endpackage

[design/kfc_datapath.sv]
`timescale 1ns / 1ps
module kfc_datapath
    import kfc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_digit,
    input  logic [1:0] i_op,
    input  logic       i_ready,
    output logic       o_valid,
    output logic       o_is_command,
    output logic [7:0] o_code,
    output logic       o_last
);

    localparam int W      = WORD_BITS;
    localparam int DIGITS = (WORD_BITS * 77) / 256 + 1;
    localparam int IW     = $clog2(DIGITS);
    localparam int CW     = $clog2(DIGITS + 1);
    localparam int NW     = $clog2(WORD_BITS + 1);
    localparam logic [W-1:0] RECIP =
        W'(((64'd1 << (W + 3)) + 64'(RADIX) - 64'd1) / 64'(RADIX));

    logic [1:0]     r_kind;
    logic [3:0]     r_digit;
    logic [1:0]     r_op;
    logic [W-1:0]   r_entry;
    logic [W-1:0]   r_first;
    logic           r_latched;
    logic [2:0]     r_pend;
    logic [W-1:0]   r_last_res;
    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_dvs;
    logic [NW-1:0]  r_div_cnt;
    logic           r_div_busy;
    logic           r_neg;
    logic           r_dz;
    logic [W-1:0]   r_mag;
    logic [3:0]     r_dig [DIGITS];
    logic [CW-1:0]  r_dig_cnt;
    logic           r_out_valid;
    logic           r_out_cmd;
    logic [7:0]     r_out_code;
    logic           r_out_last;

    logic [W:0]     n_shift;
    logic           n_ge;
    logic [W-1:0]   n_abs_a;
    logic [W-1:0]   n_abs_b;
    logic [2*W-1:0] n_prod;
    logic [2*W-1:0] n_recip_prod;
    logic [W-1:0]   n_dig_quo;
    logic [W-1:0]   n_dig_rem;
    logic [W-1:0]   n_simple;
    logic [CW-1:0]  n_rd_cnt;
    logic [7:0]     n_code;
    logic           n_cmd_bit;

    assign n_shift      = {r_rem, r_quo[W-1]};
    assign n_ge         = n_shift >= {1'b0, r_dvs};
    assign n_abs_a      = r_first[W-1] ? (~r_first + W'(1)) : r_first;
    assign n_abs_b      = r_entry[W-1] ? (~r_entry + W'(1)) : r_entry;
    assign n_prod       = r_first * r_entry;
    assign n_recip_prod = r_mag * RECIP;
    assign n_dig_quo    = W'(n_recip_prod >> (W + 3));
    assign n_dig_rem    = r_mag - ((r_quo << 3) + (r_quo << 1));
    assign n_rd_cnt     = r_dig_cnt - CW'(1);

    always_comb begin
        case (r_pend)
            PEND_ADD: n_simple = r_first + r_entry;
            PEND_SUB: n_simple = r_first - r_entry;
            PEND_MUL: n_simple = n_prod[W-1:0];
            default:  n_simple = r_last_res;
        endcase
    end

    always_comb begin
        n_cmd_bit = 1'b0;
        case (i_cmd.out_sel)
            OSEL_KEY:   n_code = CHAR_ZERO | {4'd0, r_digit};
            OSEL_CLEAR: begin
                n_code    = CMD_CLEAR;
                n_cmd_bit = 1'b1;
            end
            OSEL_HOME:  begin
                n_code    = CMD_HOME;
                n_cmd_bit = 1'b1;
            end
            OSEL_MINUS: n_code = CHAR_MINUS;
            OSEL_BUF:   n_code = CHAR_ZERO | {4'd0, r_dig[n_rd_cnt[IW-1:0]]};
            default:    n_code = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_kind  <= i_kind;
            r_digit <= i_digit;
            r_op    <= i_op;
        end
        if (i_cmd.out_load) begin
            r_out_cmd  <= n_cmd_bit;
            r_out_code <= n_code;
            r_out_last <= i_cmd.out_last;
        end
        if (i_cmd.div_start) begin
            r_quo <= n_abs_a;
            r_dvs <= n_abs_b;
            r_rem <= '0;
            r_neg <= r_first[W-1] ^ r_entry[W-1];
            r_dz  <= r_entry == '0;
        end else if (r_div_busy) begin
            r_quo <= {r_quo[W-2:0], n_ge};
            r_rem <= n_ge ? W'(n_shift - {1'b0, r_dvs}) : n_shift[W-1:0];
        end else if (i_cmd.div_conv) begin
            r_quo <= n_dig_quo;
        end
        if (i_cmd.mag_load) begin
            r_mag <= r_last_res[W-1] ? (~r_last_res + W'(1)) : r_last_res;
        end else if (i_cmd.dig_push) begin
            r_mag <= r_quo;
        end
        if (i_cmd.dig_push) begin
            r_dig[r_dig_cnt[IW-1:0]] <= n_dig_rem[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_first     <= '0;
            r_latched   <= 1'b0;
            r_pend      <= PEND_NONE;
            r_last_res  <= '0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            r_dig_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.entry_add) begin
                r_entry <= (r_entry << 3) + (r_entry << 1) + W'(r_digit);
            end else if (i_cmd.op_latch) begin
                r_entry <= '0;
            end
            if (i_cmd.op_latch) begin
                r_first   <= r_entry;
                r_latched <= 1'b1;
            end
            if (i_cmd.op_set) begin
                r_pend <= {1'b0, r_op} + 3'd1;
            end
            if (i_cmd.calc_simple) begin
                r_last_res <= n_simple;
            end else if (i_cmd.div_finish) begin
                r_last_res <= r_dz ? '0 : (r_neg ? (~r_quo + W'(1)) : r_quo);
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= NW'(W);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - NW'(1);
                if (r_div_cnt == NW'(1)) begin
                    r_div_busy <= 1'b0;
                end
            end
            if (i_cmd.mag_load) begin
                r_dig_cnt <= '0;
            end else if (i_cmd.dig_push) begin
                r_dig_cnt <= r_dig_cnt + CW'(1);
            end else if (i_cmd.dig_pop) begin
                r_dig_cnt <= n_rd_cnt;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.kind        = r_kind;
        o_status.digit_big   = r_digit > DIGIT_MAX;
        o_status.latched     = r_latched;
        o_status.op_is_div   = r_pend == PEND_DIV;
        o_status.div_busy    = r_div_busy;
        o_status.out_free    = !r_out_valid || i_ready;
        o_status.result_neg  = r_last_res[W-1];
        o_status.quo_zero    = r_quo == '0;
        o_status.dig_cnt_one = r_dig_cnt == CW'(1);
    end

    assign o_valid      = r_out_valid;
    assign o_is_command = r_out_cmd;
    assign o_code       = r_out_code;
    assign o_last       = r_out_last;

endmodule

[design/kfc_controller.sv]
`timescale 1ns / 1ps
module kfc_controller
    import kfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_sel = OSEL_KEY;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.key_load = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_status.kind)
                    KIND_DIGIT: begin
                        if (i_status.digit_big) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.entry_add = 1'b1;
                            n_state         = ST_EMIT_KEY;
                        end
                    end
                    KIND_OP: begin
                        o_cmd.op_set = 1'b1;
                        if (i_status.latched) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.op_latch = 1'b1;
                            n_state        = ST_EMIT_LATCH;
                        end
                    end
                    KIND_EQ:  n_state = i_status.latched ? ST_EQ_CLR : ST_SIGN;
                    default:  n_state = ST_EMIT_CLR;
                endcase
            end
            ST_EMIT_KEY: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_KEY;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_EMIT_LATCH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_CLEAR;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_EMIT_CLR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_CLEAR;
                    n_state        = ST_EMIT_HOME;
                end
            end
            ST_EMIT_HOME: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_HOME;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_EQ_CLR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_CLEAR;
                    n_state        = ST_CALC;
                end
            end
            ST_CALC: begin
                if (i_status.op_is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_WAIT;
                end else begin
                    o_cmd.calc_simple = 1'b1;
                    n_state           = ST_SIGN;
                end
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN: begin
                o_cmd.div_finish = 1'b1;
                n_state          = ST_SIGN;
            end
            ST_SIGN: begin
                if (!i_status.result_neg) begin
                    o_cmd.mag_load = 1'b1;
                    n_state        = ST_CONV;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_MINUS;
                    o_cmd.mag_load = 1'b1;
                    n_state        = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.div_conv = 1'b1;
                n_state        = ST_CONV_FIN;
            end
            ST_CONV_FIN: begin
                o_cmd.dig_push = 1'b1;
                n_state        = i_status.quo_zero ? ST_EMIT_DIG : ST_CONV;
            end
            ST_EMIT_DIG: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_BUF;
                    o_cmd.out_last = i_status.dig_cnt_one;
                    o_cmd.dig_pop  = 1'b1;
                    if (i_status.dig_cnt_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[design/keypad_four_function_calculator_unit.sv]
`timescale 1ns / 1ps
// Keypad calculator: one key beat in, zero to several display beats out, the final one
// marked by o_last. Keys are taken one at a time. Equals with a division first runs a
// radix-2 divider; the result is then turned into decimal by reciprocal multiplication,
// digit by digit, and the digits then go out one by one, each held by any output stall.
module keypad_four_function_calculator_unit
    import kfc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_digit,
    input  logic [1:0] i_op,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_command,
    output logic [7:0] o_code,
    output logic       o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    kfc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kfc_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_digit      (i_digit),
        .i_op         (i_op),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_is_command (o_is_command),
        .o_code       (o_code),
        .o_last       (o_last)
    );

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !status.div_busy)
        else $error("key beat taken while divider busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_cmd_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_command) |-> (o_code == CMD_CLEAR || o_code == CMD_HOME))
        else $error("bad display command");

endmodule

[bench/keypad_four_function_calculator_unit_test.sv]
`timescale 1ns / 1ps
module keypad_four_function_calculator_unit_test
    import kfc_pkg::*;
();

    localparam int WB = WORD_BITS_DEF;

    typedef struct packed {
        logic       is_command;
        logic [7:0] code;
        logic       last;
    } t_write;

    int error_count = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    class display_scoreboard;
        logic [WB-1:0] entry_value;
        logic [WB-1:0] first_operand;
        logic          latched;
        logic [2:0]    pending;
        logic [WB-1:0] result;
        t_write        writes_due[$];

        function new();
            entry_value = '0;
            first_operand = '0;
            latched = 1'b0;
            pending = PEND_NONE;
            result = '0;
        endfunction

        function void push(input logic cmd, input logic [7:0] code);
            t_write w;
            w.is_command = cmd;
            w.code = code;
            w.last = 1'b0;
            writes_due.push_back(w);
        endfunction

        function logic [WB-1:0] calc(input logic [WB-1:0] a, input logic [WB-1:0] b);
            logic signed [WB-1:0] sa;
            logic signed [WB-1:0] sb;
            sa = a;
            sb = b;
            case (pending)
                PEND_ADD: return a + b;
                PEND_SUB: return a - b;
                PEND_MUL: return a * b;
                PEND_DIV: begin
                    if (b == '0) return '0;
                    if (sa == {1'b1, {(WB-1){1'b0}}} && sb == -1) return a;
                    return sa / sb;
                end
                default: return result;
            endcase
        endfunction

        function void note_key(input logic [1:0] kind, input logic [3:0] digit,
                               input logic [1:0] op);
            int before_n;
            logic [WB-1:0] mag;
            logic [7:0] digs[$];
            t_write w;
            before_n = writes_due.size();
            case (kind)
                KIND_DIGIT: begin
                    if (digit <= DIGIT_MAX) begin
                        push(1'b0, CHAR_ZERO + digit);
                        entry_value = WB'(entry_value * 10 + digit);
                    end
                end
                KIND_OP: begin
                    if (!latched) begin
                        first_operand = entry_value;
                        entry_value = '0;
                        push(1'b1, CMD_CLEAR);
                        latched = 1'b1;
                    end
                    pending = {1'b0, op} + 3'd1;
                end
                KIND_EQ: begin
                    if (latched) begin
                        push(1'b1, CMD_CLEAR);
                        result = calc(first_operand, entry_value);
                    end
                    mag = result;
                    if (result[WB-1]) begin
                        push(1'b0, CHAR_MINUS);
                        mag = -result;
                    end
                    do begin
                        digs.push_front(CHAR_ZERO + 8'(mag % 10));
                        mag = WB'(mag / 10);
                    end while (mag != 0);
                    foreach (digs[i]) push(1'b0, digs[i]);
                end
                default: begin
                    push(1'b1, CMD_CLEAR);
                    push(1'b1, CMD_HOME);
                end
            endcase
            if (writes_due.size() > before_n) begin
                w = writes_due.pop_back();
                w.last = 1'b1;
                writes_due.push_back(w);
            end
        endfunction

        task check_write(input t_write got);
            t_write exp;
            if (writes_due.size() == 0) begin
                report($sformatf("unexpected write code %h", got.code));
                return;
            end
            exp = writes_due.pop_front();
            if (got.is_command !== exp.is_command)
                report($sformatf("is_command %b, want %b", got.is_command, exp.is_command));
            if (got.code !== exp.code)
                report($sformatf("code %h, want %h", got.code, exp.code));
            if (got.last !== exp.last)
                report($sformatf("last %b, want %b", got.last, exp.last));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_kind;
    logic [3:0] i_digit;
    logic [1:0] i_op;
    logic       o_valid;
    logic       i_ready;
    logic       o_is_command;
    logic [7:0] o_code;
    logic       o_last;

    display_scoreboard sb;
    int  hold_off = 0;
    bit  stim_done = 0;

    keypad_four_function_calculator_unit #(.WORD_BITS(WB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_digit(i_digit), .i_op(i_op), .o_valid(o_valid),
        .i_ready(i_ready), .o_is_command(o_is_command), .o_code(o_code), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("keypad_four_function_calculator_unit_test: FAIL");
        $finish;
    end

    // hold the key until it is taken
    task automatic send_key(input logic [1:0] kind, input logic [3:0] digit,
                            input logic [1:0] op);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_digit <= digit;
        i_op <= op;
        do @(posedge i_clk); while (!o_ready);
        sb.note_key(kind, digit, op);
    endtask

    task automatic gap(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic key_gapped(input logic [1:0] kind, input logic [3:0] digit,
                              input logic [1:0] op, input bit bursty);
        send_key(kind, digit, op);
        if (bursty && $urandom_range(0, 3) == 0) gap($urandom_range(1, 20));
    endtask

    task automatic drain();
        gap(1);
        while (sb.writes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic type_number(input int ndig);
        repeat (ndig) key_gapped(KIND_DIGIT, 4'($urandom_range(0, 9)), 2'($urandom), 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_write('{o_is_command, o_code, o_last});
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 60) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial begin
        int n;
        int d;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_DIGIT;
        i_digit = 4'd0;
        i_op = 2'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd15, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd10, 2'd0, 1'b0);
        key_gapped(KIND_CLR, 4'd15, 2'd3, 1'b0);
        key_gapped(KIND_DIGIT, 4'd3, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd2, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd7, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd6, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd8, 2'd0, 1'b0);
        key_gapped(KIND_OP, 4'd0, 2'd3, 1'b0);
        key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_OP, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_OP, 4'd0, 2'd2, 1'b0);
        key_gapped(KIND_OP, 4'd0, 2'd1, 1'b0);
        key_gapped(KIND_DIGIT, 4'd9, 2'd0, 1'b0);
        key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_OP, 4'd0, 2'd3, 1'b0);
        key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_DIGIT, 4'd0, 2'd0, 1'b0);
        key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        drain();

        // hold the output while keys keep coming
        hold_off = 400;
        repeat (12) key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b0);
        drain();

        n = 0;
        while (n < 340) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    d = $urandom_range(1, 6);
                    type_number(d);
                    key_gapped(KIND_OP, 4'd0, 2'($urandom), 1'b1);
                    n += d + 1;
                end
                4, 5: begin
                    key_gapped(KIND_EQ, 4'd0, 2'd0, 1'b1);
                    n++;
                end
                6: begin
                    key_gapped(KIND_DIGIT, 4'($urandom_range(0, 15)), 2'($urandom), 1'b1);
                    n++;
                end
                7: begin
                    key_gapped(KIND_CLR, 4'($urandom), 2'($urandom), 1'b1);
                    n++;
                end
                8: begin
                    key_gapped(KIND_OP, 4'($urandom), 2'($urandom), 1'b1);
                    n++;
                end
                default: begin
                    d = $urandom_range(1, 5);
                    type_number(d);
                    key_gapped(KIND_EQ, 4'($urandom), 2'($urandom), 1'b1);
                    n += d + 1;
                end
            endcase
            if ($urandom_range(0, 40) == 0) drain();
        end
        drain();
        gap(0);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("keypad_four_function_calculator_unit_test: PASS");
        end else begin
            $display("keypad_four_function_calculator_unit_test: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/kfc_pkg.sv
design/kfc_datapath.sv
design/kfc_controller.sv
design/keypad_four_function_calculator_unit.sv
bench/keypad_four_function_calculator_unit_test.sv
